// ----- rtl/core/pnslt_pkg.sv -----
// Package for the per-node sequence loss tracker.
// Holds field widths, reset values, register indexes, status codes,
// the controller state type and the controller command struct.
`default_nettype none

package pnslt_pkg;

  localparam int NODE_COUNT_DEF = 16;

  localparam int NODE_W    = 8;
  localparam int SEQ_W     = 16;
  localparam int CNT_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int ADDED_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 16;

  // One table row: last sequence, received count, lost count
  localparam int ENTRY_W = SEQ_W + 2 * CNT_W;

  localparam logic [CFG_W-1:0] RESYNC_RESET = 16'd30000;
  localparam logic [CFG_W-1:0] GAP_RESET    = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 8'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_BAD     = 3'd0,
    ST_FIRST   = 3'd1,
    ST_DUP     = 3'd2,
    ST_RESYNC  = 3'd3,
    ST_COUNTED = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, launch table read
    logic commit;   // write back entry, load result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/pnslt_if.sv -----
// Channel interfaces of the per-node sequence loss tracker.
// Depends on pnslt_pkg for field widths.
`default_nettype none

interface pnslt_in_if;
  logic                          valid;
  logic                          ready;
  logic [pnslt_pkg::NODE_W-1:0]  node_number;
  logic [pnslt_pkg::SEQ_W-1:0]   sequence_number;

  modport source (output valid, node_number, sequence_number, input ready);
  modport sink   (input valid, node_number, sequence_number, output ready);
endinterface

interface pnslt_out_if;
  logic                           valid;
  logic                           ready;
  logic [pnslt_pkg::STATUS_W-1:0] status;
  logic [pnslt_pkg::CNT_W-1:0]    received_total;
  logic [pnslt_pkg::CNT_W-1:0]    lost_total;
  logic [pnslt_pkg::ADDED_W-1:0]  lost_added;

  modport source (output valid, status, received_total, lost_total, lost_added,
                  input ready);
  modport sink   (input valid, status, received_total, lost_total, lost_added,
                  output ready);
endinterface

interface pnslt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pnslt_pkg::CFG_IDX_W-1:0] index;
  logic [pnslt_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pnslt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module pnslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pnslt_ctrl.sv -----
// Controller of the per-node sequence loss tracker: request handshake,
// result valid and datapath commands. Depends on pnslt_pkg.
`default_nettype none

module pnslt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pnslt_pkg::ctrl_cmd_t       cmd
);

  pnslt_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  // hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pnslt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      pnslt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = pnslt_pkg::S_EXEC;
        end
      end
      pnslt_pkg::S_EXEC: begin
        // wait until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pnslt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pnslt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/pnslt_dpath.sv -----
// Datapath of the per-node sequence loss tracker: configuration registers,
// per-node table (valid flags plus RAM), classify and update logic, result
// register. Depends on pnslt_pkg and pnslt_ram.
`default_nettype none

module pnslt_dpath #(
  parameter int NODE_COUNT = pnslt_pkg::NODE_COUNT_DEF,
  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pnslt_pkg::ctrl_cmd_t              cmd,
  input  wire logic [pnslt_pkg::NODE_W-1:0]      in_node,
  input  wire logic [pnslt_pkg::SEQ_W-1:0]       in_seq,
  input  wire logic                              cfg_we,
  input  wire logic [pnslt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pnslt_pkg::CFG_W-1:0]       cfg_data,
  output logic      [pnslt_pkg::STATUS_W-1:0]    out_status,
  output logic      [pnslt_pkg::CNT_W-1:0]       out_received,
  output logic      [pnslt_pkg::CNT_W-1:0]       out_lost,
  output logic      [pnslt_pkg::ADDED_W-1:0]     out_added
);

  localparam int SEQ_W = pnslt_pkg::SEQ_W;
  localparam int CNT_W = pnslt_pkg::CNT_W;

  logic [pnslt_pkg::CFG_W-1:0]   resync_r, gap_r;
  logic [NODE_COUNT-1:0]         valid_r;
  logic [IDX_W-1:0]              idx_r;
  logic                          bad_r;
  logic [SEQ_W-1:0]              seq_r;

  logic [pnslt_pkg::ENTRY_W-1:0] rd_entry, wr_entry;
  logic [SEQ_W-1:0]              last_q, new_last, diff, diff_m1;
  logic [CNT_W-1:0]              recv_q, lost_q, recv_inc, lost_sat;
  logic [CNT_W-1:0]              new_recv, new_lost;
  logic [CNT_W:0]                lost_sum;
  logic [pnslt_pkg::ADDED_W-1:0] added;
  pnslt_pkg::status_t            status;
  logic                          valid_q;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resync_r <= pnslt_pkg::RESYNC_RESET;
      gap_r    <= pnslt_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pnslt_pkg::CFG_RESYNC: resync_r <= cfg_data;
        pnslt_pkg::CFG_GAP:    gap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_node[IDX_W-1:0];
      bad_r <= ({1'b0, in_node} >= 9'(NODE_COUNT));
      seq_r <= in_seq;
    end
  end

  // entry valid flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && !bad_r) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  pnslt_ram #(
    .WIDTH (pnslt_pkg::ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (cmd.commit && !bad_r),
    .waddr (idx_r),
    .wdata (wr_entry),
    .re    (cmd.capture),
    .raddr (in_node[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // classify the sequence step and update the entry
  always_comb begin
    {last_q, recv_q, lost_q} = rd_entry;
    valid_q  = valid_r[idx_r];
    diff     = seq_r - last_q;
    diff_m1  = diff - 16'd1;
    recv_inc = (recv_q == '1) ? recv_q : recv_q + 32'd1;
    lost_sum = {1'b0, lost_q} + {{(CNT_W + 1 - SEQ_W){1'b0}}, diff_m1};
    lost_sat = lost_sum[CNT_W] ? '1 : lost_sum[CNT_W-1:0];

    new_last = last_q;
    new_recv = recv_q;
    new_lost = lost_q;
    added    = '0;
    if (bad_r) begin
      status = pnslt_pkg::ST_BAD;
    end else if (!valid_q) begin
      status   = pnslt_pkg::ST_FIRST;
      new_last = seq_r;
      new_recv = 32'd1;
      new_lost = '0;
    end else if (diff == '0) begin
      status = pnslt_pkg::ST_DUP;
    end else if (diff > resync_r) begin
      status   = pnslt_pkg::ST_RESYNC;
      new_last = seq_r;
    end else if (diff < gap_r) begin
      status   = pnslt_pkg::ST_COUNTED;
      new_last = seq_r;
      new_recv = recv_inc;
      new_lost = lost_sat;
      added    = diff_m1;
    end else begin
      status = pnslt_pkg::ST_IGNORED;
    end
    wr_entry = {new_last, new_recv, new_lost};
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status   <= status;
      out_received <= bad_r ? '0 : new_recv;
      out_lost     <= bad_r ? '0 : new_lost;
      out_added    <= added;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/per_node_sequence_loss_tracker.sv -----
// Top level of the per-node sequence loss tracker.
// Depends on pnslt_pkg, pnslt_if, pnslt_ctrl, pnslt_dpath.
//
//   channel  direction  carries
//   in_if    sink       node_number, sequence_number
//   out_if   source     status, received_total, lost_total, lost_added
//   cfg_if   sink       index (0 resync threshold, 1 gap limit), data
//
// A request is handled as accept plus table read, then classify and write
// back; the single read-modify-write on the node table RAM sets this order.
// A finished result sits in the output register; the next request is
// accepted while it waits, and only its commit waits for out_if.ready.
// Reset (rst_n low, synchronous) clears all valid flags at once, so no
// clearing pass is needed. cfg_if.ready is always high.
`default_nettype none

module per_node_sequence_loss_tracker #(
  parameter int NODE_COUNT = pnslt_pkg::NODE_COUNT_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pnslt_in_if.sink     in_if,
  pnslt_out_if.source  out_if,
  pnslt_cfg_if.sink    cfg_if
);

  pnslt_pkg::ctrl_cmd_t cmd;

  assign cfg_if.ready = 1'b1;

  pnslt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  pnslt_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_node      (in_if.node_number),
    .in_seq       (in_if.sequence_number),
    .cfg_we       (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .out_status   (out_if.status),
    .out_received (out_if.received_total),
    .out_lost     (out_if.lost_total),
    .out_added    (out_if.lost_added)
  );

endmodule

`default_nettype wire

// ----- rtl/core/pnslt_checker.sv -----
// Port-level checker for the per-node sequence loss tracker, bound to the
// top level. Depends on pnslt_pkg.
`default_nettype none

module pnslt_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic [pnslt_pkg::STATUS_W-1:0]    status,
  input wire logic [pnslt_pkg::CNT_W-1:0]       received_total,
  input wire logic [pnslt_pkg::CNT_W-1:0]       lost_total,
  input wire logic [pnslt_pkg::ADDED_W-1:0]     lost_added
);

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in work");

  // bad node results carry no counters
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == pnslt_pkg::ST_BAD) |->
      (received_total == '0 && lost_total == '0 && lost_added == '0))
    else $error("bad node result with nonzero counters");

  // first packet restarts the counters
  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == pnslt_pkg::ST_FIRST) |->
      (received_total == 32'd1 && lost_total == '0 && lost_added == '0))
    else $error("first packet result with wrong counters");

  // only counted steps report losses
  a_added_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != pnslt_pkg::ST_COUNTED) |-> (lost_added == '0))
    else $error("losses reported on a step that was not counted");

  // a known entry has seen at least one packet
  a_recv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != pnslt_pkg::ST_BAD) |-> (received_total != '0))
    else $error("valid node result with zero received count");

endmodule

bind per_node_sequence_loss_tracker pnslt_checker u_pnslt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .status         (out_if.status),
  .received_total (out_if.received_total),
  .lost_total     (out_if.lost_total),
  .lost_added     (out_if.lost_added)
);

`default_nettype wire

// ----- bench/per_node_sequence_loss_tracker_tb.sv -----
// Self-checking testbench for per_node_sequence_loss_tracker: directed packet reports,
// then random report streams under several register settings with random stalls.
// Depends on pnslt_pkg, the channel interfaces in pnslt_if and the tracker RTL.

module per_node_sequence_loss_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES     = pnslt_pkg::NODE_COUNT_DEF;
  localparam int NODE_W    = pnslt_pkg::NODE_W;
  localparam int SEQ_W     = pnslt_pkg::SEQ_W;
  localparam int CNT_W     = pnslt_pkg::CNT_W;
  localparam int ADDED_W   = pnslt_pkg::ADDED_W;
  localparam int CFG_IDX_W = pnslt_pkg::CFG_IDX_W;
  localparam int CFG_W     = pnslt_pkg::CFG_W;

  // Register indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX  = 8'hFF;

  typedef struct packed {
    pnslt_pkg::status_t status;
    logic [CNT_W-1:0]   received;
    logic [CNT_W-1:0]   lost;
    logic [ADDED_W-1:0] added;
  } loss_result_t;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0]  seq;
    bit                typed;
    loss_result_t      want;
  } report_row_t;

  logic clk;
  logic rst_n;

  pnslt_in_if  in_if ();
  pnslt_out_if out_if ();
  pnslt_cfg_if cfg_if ();

  per_node_sequence_loss_tracker #(.NODE_COUNT(NODES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Shadow copy of the node table and registers
  bit               node_live     [NODES];
  logic [SEQ_W-1:0] node_last_seq [NODES];
  logic [CNT_W-1:0] node_received [NODES];
  logic [CNT_W-1:0] node_lost     [NODES];
  logic [CFG_W-1:0] resync_cfg;
  logic [CFG_W-1:0] gap_cfg;

  loss_result_t due_results[$];
  loss_result_t oldest_due;
  int           error_count;
  bit           pace_on;
  bit           hold_off_req;

  // Directed reports; typed rows hold results read straight off the rules
  report_row_t script [19] = '{
    '{8'd255, 16'hFFFF, 1'b1, '{pnslt_pkg::ST_BAD,     32'd0, 32'd0, 16'd0}},
    '{8'd16,  16'h1234, 1'b1, '{pnslt_pkg::ST_BAD,     32'd0, 32'd0, 16'd0}},
    '{8'd0,   16'd0,    1'b1, '{pnslt_pkg::ST_FIRST,   32'd1, 32'd0, 16'd0}},
    '{8'd0,   16'd0,    1'b1, '{pnslt_pkg::ST_DUP,     32'd1, 32'd0, 16'd0}},
    '{8'd0,   16'd1,    1'b1, '{pnslt_pkg::ST_COUNTED, 32'd2, 32'd0, 16'd0}},
    '{8'd0,   16'd999,  1'b0, '0},
    '{8'd0,   16'd1999, 1'b0, '0},
    '{8'd0,   16'd31000, 1'b0, '0},
    '{8'd0,   16'd61000, 1'b0, '0},
    '{8'd0,   16'd31999, 1'b0, '0},
    '{8'd15,  16'hFFFF, 1'b1, '{pnslt_pkg::ST_FIRST,   32'd1, 32'd0, 16'd0}},
    '{8'd15,  16'h0000, 1'b1, '{pnslt_pkg::ST_COUNTED, 32'd2, 32'd0, 16'd0}},
    '{8'd15,  16'hFFFF, 1'b1, '{pnslt_pkg::ST_RESYNC,  32'd2, 32'd0, 16'd0}},
    '{8'd7,   16'hAAAA, 1'b1, '{pnslt_pkg::ST_FIRST,   32'd1, 32'd0, 16'd0}},
    '{8'd7,   16'h5555, 1'b0, '0},
    '{8'd128, 16'h5555, 1'b1, '{pnslt_pkg::ST_BAD,     32'd0, 32'd0, 16'd0}},
    '{8'd7,   16'h5556, 1'b0, '0},
    '{8'd1,   16'h8000, 1'b0, '0},
    '{8'd1,   16'h81F4, 1'b0, '0}
  };

  // Clock
  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Classify one report against the shadow table and update it
  function automatic loss_result_t track_report(logic [NODE_W-1:0] node,
                                                logic [SEQ_W-1:0] seq);
    loss_result_t r;
    logic [SEQ_W-1:0] diff;
    r = '0;
    if (node >= NODES) begin
      r.status = pnslt_pkg::ST_BAD;
      return r;
    end
    if (!node_live[node]) begin
      node_live[node]     = 1'b1;
      node_last_seq[node] = seq;
      node_received[node] = 32'd1;
      node_lost[node]     = '0;
      r.status = pnslt_pkg::ST_FIRST;
    end else begin
      diff = seq - node_last_seq[node];
      if (diff == 0) begin
        r.status = pnslt_pkg::ST_DUP;
      end else if (diff > resync_cfg) begin
        node_last_seq[node] = seq;
        r.status = pnslt_pkg::ST_RESYNC;
      end else if (diff < gap_cfg) begin
        r.added             = diff - 1'b1;
        node_lost[node]     = sat_sum(node_lost[node], {16'd0, r.added});
        node_received[node] = sat_sum(node_received[node], 32'd1);
        node_last_seq[node] = seq;
        r.status = pnslt_pkg::ST_COUNTED;
      end else begin
        r.status = pnslt_pkg::ST_IGNORED;
      end
    end
    r.received = node_received[node];
    r.lost     = node_lost[node];
    return r;
  endfunction

  function automatic int pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_gap();
    if (!pace_on || $urandom_range(0, 99) < 55) return 0;
    return pick_stall();
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Offer one request, wait for its handshake, then queue its result
  task automatic send_report(input logic [NODE_W-1:0] node, input logic [SEQ_W-1:0] seq,
                             input bit typed, input loss_result_t typed_want);
    int gap;
    loss_result_t pred;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.node_number     <= node;
    in_if.sequence_number <= seq;
    do @(posedge clk); while (!in_if.ready);
    pred = track_report(node, seq);
    due_results.push_back(typed ? typed_want : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == pnslt_pkg::CFG_RESYNC) resync_cfg = value;
    else if (idx == pnslt_pkg::CFG_GAP) gap_cfg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop valid and wait until every result has drained
  task automatic settle_block();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly follow each node's stream; mix in duplicates, jumps, bad nodes and noise
  task automatic make_report(output logic [NODE_W-1:0] node, output logic [SEQ_W-1:0] seq);
    int unsigned pick, lo, hi;
    logic [SEQ_W-1:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      node = NODE_W'($urandom_range(NODES, 255));
      seq  = SEQ_W'($urandom);
      return;
    end
    node = NODE_W'($urandom_range(0, NODES - 1));
    if (!node_live[node] || pick >= 95) begin
      seq = SEQ_W'($urandom);
      return;
    end
    if (pick < 70) begin
      hi = (gap_cfg > 1) ? gap_cfg - 1 : 1;
      if ($urandom_range(0, 3) == 0) d = SEQ_W'($urandom_range(1, hi));
      else d = SEQ_W'($urandom_range(1, (hi < 4) ? hi : 4));
    end else if (pick < 78) begin
      d = '0;
    end else if (pick < 87) begin
      lo = resync_cfg;
      d  = (lo < 65535) ? SEQ_W'($urandom_range(lo + 1, 65535)) : SEQ_W'($urandom);
    end else begin
      lo = (gap_cfg == 0) ? 1 : gap_cfg;
      hi = resync_cfg;
      d  = (lo <= hi) ? SEQ_W'($urandom_range(lo, hi)) : SEQ_W'($urandom);
    end
    seq = node_last_seq[node] + d;
  endtask

  task automatic run_random(input int count);
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0]  seq;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) pace_on = ($urandom_range(0, 3) != 0);
      make_report(node, seq);
      send_report(node, seq, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] resync, input logic [CFG_W-1:0] gap,
                           input int count);
    settle_block();
    write_reg(pnslt_pkg::CFG_RESYNC, resync);
    write_reg(pnslt_pkg::CFG_GAP, gap);
    run_random(count);
  endtask

  // Result ready: random stalls, plus one long hold-off on request
  initial begin : sink_pacing
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = 400;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && pace_on && $urandom_range(0, 99) < 20)
          stall_left = pick_stall();
        out_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result status %0d", out_if.status));
      end else begin
        oldest_due = due_results.pop_front();
        if (out_if.status !== oldest_due.status)
          flag_error($sformatf("status got %0d want %0d", out_if.status, oldest_due.status));
        if (out_if.received_total !== oldest_due.received)
          flag_error($sformatf("received_total got %0d want %0d",
                               out_if.received_total, oldest_due.received));
        if (out_if.lost_total !== oldest_due.lost)
          flag_error($sformatf("lost_total got %0d want %0d",
                               out_if.lost_total, oldest_due.lost));
        if (out_if.lost_added !== oldest_due.added)
          flag_error($sformatf("lost_added got %0d want %0d",
                               out_if.lost_added, oldest_due.added));
      end
    end
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("per_node_sequence_loss_tracker_tb NOT OK");
    $finish;
  end

  initial begin : main_flow
    logic [SEQ_W-1:0] next_seq;
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.node_number     = '0;
    in_if.sequence_number = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    error_count           = 0;
    pace_on               = 1'b1;
    hold_off_req          = 1'b0;
    resync_cfg            = pnslt_pkg::RESYNC_RESET;
    gap_cfg               = pnslt_pkg::GAP_RESET;
    for (int n = 0; n < NODES; n++) begin
      node_live[n]     = 1'b0;
      node_last_seq[n] = '0;
      node_received[n] = '0;
      node_lost[n]     = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed reports under reset register values
    foreach (script[k])
      send_report(script[k].node, script[k].seq, script[k].typed, script[k].want);

    // Reset values, with a long receiver hold-off in the middle
    run_random(150);
    hold_off_req = 1'b1;
    run_random(150);

    // Widest windows; a write to an unused index changes nothing
    run_phase(16'hFFFF, 16'hFFFF, 200);
    settle_block();
    write_reg(CFG_SPARE_IDX, 16'h0001);
    run_random(50);

    // Every jump resyncs, nothing counted
    run_phase(16'h0000, 16'h0001, 150);

    // Gap limit zero: every nonzero step is ignored
    run_phase(16'hFFFF, 16'h0000, 120);
    settle_block();
    write_reg(CFG_LAST_IDX, 16'hFFFF);
    run_random(30);

    // Random settings
    run_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(1, 65535)), 150);
    run_phase(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(1, 2000)), 150);

    // Back-to-back maximal counted steps on node 3
    settle_block();
    write_reg(pnslt_pkg::CFG_RESYNC, 16'hFFFF);
    write_reg(pnslt_pkg::CFG_GAP, 16'hFFFF);
    pace_on = 1'b0;
    send_report(8'd3, SEQ_W'($urandom), 1'b0, '0);
    for (int i = 0; i < 20; i++) begin
      next_seq = node_last_seq[3] + 16'd65534;
      send_report(8'd3, next_seq, 1'b0, '0);
    end

    // Back to reset values
    run_phase(pnslt_pkg::RESYNC_RESET, pnslt_pkg::GAP_RESET, 100);

    // Drain and let the pipeline go quiet
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("per_node_sequence_loss_tracker_tb OK");
    end else begin
      $display("per_node_sequence_loss_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
